[src/lwcf_pkg.sv]
// Shared types, constants and helpers for the LCD window clip and fill sequencer.
package lwcf_pkg;

   localparam int DEFAULT_PANEL_WIDTH  = 240;
   localparam int DEFAULT_PANEL_HEIGHT = 320;
   localparam int MAX_PANEL_DIM        = 1024;
   localparam int COORD_W              = $clog2(MAX_PANEL_DIM);
   localparam int IN_W                 = 16;
   localparam int CLIP_W               = IN_W + 1;
   localparam int COLOR_W              = 16;
   localparam int VALUE_W              = 16;
   localparam int COUNT_W              = 17;
   localparam int REG_W                = 8;
   localparam int QUEUE_DEPTH          = 4;
   localparam int STEP_W               = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [REG_W-1:0] REG_NONE   = 8'h00;
   localparam logic [REG_W-1:0] REG_CUR_X  = 8'h20;
   localparam logic [REG_W-1:0] REG_CUR_Y  = 8'h21;
   localparam logic [REG_W-1:0] REG_GRAM   = 8'h22;
   localparam logic [REG_W-1:0] REG_WIN_X0 = 8'h50;
   localparam logic [REG_W-1:0] REG_WIN_X1 = 8'h51;
   localparam logic [REG_W-1:0] REG_WIN_Y0 = 8'h52;
   localparam logic [REG_W-1:0] REG_WIN_Y1 = 8'h53;

   localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_PIX_START = 4'd5;
   localparam logic [STEP_W-1:0] STEP_RECT_LAST = 4'd7;
   localparam logic [STEP_W-1:0] STEP_PIX_LAST  = 4'd8;

   typedef enum logic [1:0] {
      KIND_REG   = 2'd0,
      KIND_SEL   = 2'd1,
      KIND_BURST = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CMD_RECT    = 3'b001,
      CMD_PIX_WIN = 3'b010,
      CMD_PIX     = 3'b100
   } cmd_kind_type;

   typedef enum logic [2:0] {
      SRC_X1,
      SRC_Y1,
      SRC_X2,
      SRC_Y2,
      SRC_ZERO,
      SRC_MAXX,
      SRC_MAXY,
      SRC_BURST
   } src_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y2;
      logic [COLOR_W-1:0] color;
   } cmd_type;

   typedef struct packed {
      kind_type         kind;
      logic [REG_W-1:0] reg_index;
      src_type          src;
   } seq_type;

   typedef struct packed {
      kind_type           kind;
      logic [REG_W-1:0]   reg_index;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] pixel_count;
      logic               last;
   } rsp_type;

   function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [CLIP_W-1:0] v,
                                                      input logic signed [CLIP_W-1:0] max);
      logic [COORD_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > max) begin
         r = max[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/lwcf_if.sv]
// Request and response channel interfaces.
interface lwcf_req_if;
   import lwcf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic signed [IN_W-1:0] x_first;
   logic signed [IN_W-1:0] y_first;
   logic signed [IN_W-1:0] x_second;
   logic signed [IN_W-1:0] y_second;
   logic [COLOR_W-1:0]     pixel_color;

   modport source (output valid, func, x_first, y_first, x_second, y_second, pixel_color,
                   input ready);
   modport sink (input valid, func, x_first, y_first, x_second, y_second, pixel_color,
                 output ready);
endinterface

interface lwcf_rsp_if;
   import lwcf_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [REG_W-1:0]   reg_index;
   logic [VALUE_W-1:0] value;
   logic [COUNT_W-1:0] pixel_count;
   logic               last;

   modport source (output valid, kind, reg_index, value, pixel_count, last, input ready);
   modport sink (input valid, kind, reg_index, value, pixel_count, last, output ready);
endinterface

[src/lwcf_front.sv]
// Front end: rotate, clip and classify commands, track the full-window flag.
module lwcf_front #(
   parameter int PANEL_WIDTH  = lwcf_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = lwcf_pkg::DEFAULT_PANEL_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              landscape_mode,
   lwcf_req_if.sink          req,
   input  logic              q_full,
   output logic              q_push,
   output lwcf_pkg::cmd_type q_data
);
   import lwcf_pkg::*;

   localparam logic signed [CLIP_W-1:0] MAXX = CLIP_W'(PANEL_WIDTH - 1);
   localparam logic signed [CLIP_W-1:0] MAXY = CLIP_W'(PANEL_HEIGHT - 1);

   logic                     full_window_ff;
   logic                     full_window_in;
   logic signed [CLIP_W-1:0] rx1;
   logic signed [CLIP_W-1:0] ry1;
   logic signed [CLIP_W-1:0] rx2;
   logic signed [CLIP_W-1:0] ry2;
   logic signed [CLIP_W-1:0] py;
   logic                     x_off;
   logic                     y_off;
   logic                     pix_off;
   logic                     drop;
   logic                     accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (landscape_mode) begin
         rx1 = CLIP_W'(req.y_first);
         rx2 = CLIP_W'(req.y_second);
         ry1 = MAXY - CLIP_W'(req.x_second);
         ry2 = MAXY - CLIP_W'(req.x_first);
         py  = ry2;
      end else begin
         rx1 = CLIP_W'(req.x_first);
         rx2 = CLIP_W'(req.x_second);
         ry1 = CLIP_W'(req.y_first);
         ry2 = CLIP_W'(req.y_second);
         py  = ry1;
      end
      x_off   = (rx1 < 0 && rx2 < 0) || (rx1 > MAXX && rx2 > MAXX);
      y_off   = (ry1 < 0 && ry2 < 0) || (ry1 > MAXY && ry2 > MAXY);
      pix_off = rx1 < 0 || rx1 > MAXX || py < 0 || py > MAXY;
      drop    = req.func ? pix_off : (x_off || y_off);

      q_data.color = req.pixel_color;
      q_data.x1    = clamp_coord(rx1, MAXX);
      q_data.x2    = clamp_coord(rx2, MAXX);
      q_data.y2    = clamp_coord(ry2, MAXY);
      if (req.func) begin
         q_data.kind = full_window_ff ? CMD_PIX : CMD_PIX_WIN;
         q_data.y1   = clamp_coord(py, MAXY);
      end else begin
         q_data.kind = CMD_RECT;
         q_data.y1   = clamp_coord(ry1, MAXY);
      end

      q_push         = accept && !drop;
      full_window_in = full_window_ff;
      if (q_push) begin
         full_window_in = req.func;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_window_ff <= 1'b0;
      end else begin
         full_window_ff <= full_window_in;
      end
   end

endmodule

[src/lwcf_queue.sv]
// Short command queue between the front and back ends.
module lwcf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lwcf_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lwcf_pkg::cmd_type head_data
);
   import lwcf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/lwcf_back.sv]
// Back end: step through the register writes and burst of each queued command.
module lwcf_back #(
   parameter int PANEL_WIDTH  = lwcf_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = lwcf_pkg::DEFAULT_PANEL_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lwcf_pkg::cmd_type q_data,
   output logic              q_pop,
   lwcf_rsp_if.source        rsp
);
   import lwcf_pkg::*;

   localparam int SPAN_W = COORD_W + 1;
   localparam int PROD_W = 2 * SPAN_W;
   localparam logic [VALUE_W-1:0] MAXX_V = VALUE_W'(PANEL_WIDTH - 1);
   localparam logic [VALUE_W-1:0] MAXY_V = VALUE_W'(PANEL_HEIGHT - 1);

   cmd_type             cmd_ff;
   cmd_type             cmd_in;
   logic                busy_ff;
   logic                busy_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [SPAN_W-1:0]   span_x_ff;
   logic [SPAN_W-1:0]   span_y_ff;
   logic                empty_ff;
   logic [PROD_W-1:0]   product_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   rsp_type             out_ff;
   rsp_type             out_in;
   seq_type             seq;
   logic [COUNT_W-1:0]  rect_count;
   logic                is_rect;
   logic                advance;
   logic                emit;
   logic                is_last;
   logic                load;

   function automatic seq_type seq_entry(input logic rect, input logic [STEP_W-1:0] step);
      seq_type s;
      s = '{kind: KIND_SEL, reg_index: REG_GRAM, src: SRC_ZERO};
      if (rect) begin
         case (step)
            4'd0:    s = '{kind: KIND_REG, reg_index: REG_CUR_X, src: SRC_X1};
            4'd1:    s = '{kind: KIND_REG, reg_index: REG_CUR_Y, src: SRC_Y1};
            4'd2:    s = '{kind: KIND_REG, reg_index: REG_WIN_X0, src: SRC_X1};
            4'd3:    s = '{kind: KIND_REG, reg_index: REG_WIN_Y0, src: SRC_Y1};
            4'd4:    s = '{kind: KIND_REG, reg_index: REG_WIN_X1, src: SRC_X2};
            4'd5:    s = '{kind: KIND_REG, reg_index: REG_WIN_Y1, src: SRC_Y2};
            4'd7:    s = '{kind: KIND_BURST, reg_index: REG_NONE, src: SRC_BURST};
            default: s = '{kind: KIND_SEL, reg_index: REG_GRAM, src: SRC_ZERO};
         endcase
      end else begin
         case (step)
            4'd0:    s = '{kind: KIND_REG, reg_index: REG_WIN_X0, src: SRC_ZERO};
            4'd1:    s = '{kind: KIND_REG, reg_index: REG_WIN_X1, src: SRC_MAXX};
            4'd2:    s = '{kind: KIND_REG, reg_index: REG_WIN_Y0, src: SRC_ZERO};
            4'd3:    s = '{kind: KIND_REG, reg_index: REG_WIN_Y1, src: SRC_MAXY};
            4'd5:    s = '{kind: KIND_REG, reg_index: REG_CUR_X, src: SRC_X1};
            4'd6:    s = '{kind: KIND_REG, reg_index: REG_CUR_Y, src: SRC_Y1};
            4'd8:    s = '{kind: KIND_BURST, reg_index: REG_NONE, src: SRC_BURST};
            default: s = '{kind: KIND_SEL, reg_index: REG_GRAM, src: SRC_ZERO};
         endcase
      end
      return s;
   endfunction

   assign is_rect = cmd_ff.kind == CMD_RECT;
   assign advance = !out_valid_ff || rsp.ready;
   assign emit    = busy_ff && advance;
   assign is_last = step_ff == (is_rect ? STEP_RECT_LAST : STEP_PIX_LAST);
   assign load    = q_valid && (!busy_ff || (emit && is_last));
   assign q_pop   = load;
   assign seq     = seq_entry(is_rect, step_ff);

   always_comb begin
      if (empty_ff) begin
         rect_count = '0;
      end else if (product_ff > PROD_W'(COUNT_MAX)) begin
         rect_count = COUNT_MAX;
      end else begin
         rect_count = product_ff[COUNT_W-1:0];
      end
   end

   always_comb begin
      cmd_in  = cmd_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (load) begin
         cmd_in  = q_data;
         busy_in = 1'b1;
         step_in = (q_data.kind == CMD_PIX) ? STEP_PIX_START : STEP_FIRST;
      end else if (emit && is_last) begin
         busy_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
      end

      out_valid_in = advance ? busy_ff : out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_in.kind        = seq.kind;
         out_in.reg_index   = seq.reg_index;
         out_in.last        = is_last;
         out_in.pixel_count = '0;
         case (seq.src)
            SRC_X1:    out_in.value = VALUE_W'(cmd_ff.x1);
            SRC_Y1:    out_in.value = VALUE_W'(cmd_ff.y1);
            SRC_X2:    out_in.value = VALUE_W'(cmd_ff.x2);
            SRC_Y2:    out_in.value = VALUE_W'(cmd_ff.y2);
            SRC_MAXX:  out_in.value = MAXX_V;
            SRC_MAXY:  out_in.value = MAXY_V;
            SRC_BURST: begin
               out_in.value       = cmd_ff.color;
               out_in.pixel_count = is_rect ? rect_count : COUNT_W'(1);
            end
            default:   out_in.value = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      out_ff     <= out_in;
      span_x_ff  <= SPAN_W'(cmd_ff.x2) - SPAN_W'(cmd_ff.x1) + SPAN_W'(1);
      span_y_ff  <= SPAN_W'(cmd_ff.y2) - SPAN_W'(cmd_ff.y1) + SPAN_W'(1);
      empty_ff   <= (cmd_ff.x2 < cmd_ff.x1) || (cmd_ff.y2 < cmd_ff.y1);
      product_ff <= span_x_ff * span_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_ff.kind;
   assign rsp.reg_index   = out_ff.reg_index;
   assign rsp.value       = out_ff.value;
   assign rsp.pixel_count = out_ff.pixel_count;
   assign rsp.last        = out_ff.last;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= STEP_PIX_LAST)
      else $error("sequence step past final result");

   a_burst_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == KIND_BURST) |-> out_ff.last)
      else $error("burst transaction not marked last");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && (step_ff == STEP_FIRST || step_ff == STEP_PIX_START))
      else $error("command load did not start a sequence");

endmodule

[src/lcd_window_clip_fill_sequencer.sv]
// Top level of the LCD window clip and fill sequencer.
//
//   channel  direction  handshake        content
//   req      in         valid / ready    drawing command: func, corners, color
//   rsp      out        valid / ready    bus transaction: kind, reg_index, value, count, last
//   csr      in         csr_we           landscape_mode in csr_wdata
//
// A rectangle fill gives 8 transactions, a pixel 9 on first use of the full window and 4 after,
// one per cycle from the back end while rsp is ready; the output register sets that pace.
// A taken command passes the queue, command register and output register; a drop emits nothing.
// The front end takes a new command every cycle while the 4-entry queue has room.
// Reset is synchronous; it clears the queue, the full-window flag and landscape_mode.
// A stalled rsp holds the back end; the front end keeps filling the queue.
module lcd_window_clip_fill_sequencer #(
   parameter int PANEL_WIDTH  = lwcf_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = lwcf_pkg::DEFAULT_PANEL_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   lwcf_req_if.sink   req,
   lwcf_rsp_if.source rsp,
   input  logic       csr_we,
   input  logic       csr_wdata
);
   import lwcf_pkg::*;

   logic    landscape_ff;
   logic    landscape_in;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_push_data;
   cmd_type q_head_data;

   assign landscape_in = csr_we ? csr_wdata : landscape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         landscape_ff <= 1'b0;
      end else begin
         landscape_ff <= landscape_in;
      end
   end

   lwcf_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .landscape_mode (landscape_ff),
      .req            (req),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   lwcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head_data)
   );

   lwcf_back #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_head_data),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

[tb/sv/tb_lcd_window_clip_fill_sequencer.sv]
// Self-checking testbench for the LCD window clip and fill sequencer.
`timescale 1ns / 1ps

module tb_lcd_window_clip_fill_sequencer;
   import lwcf_pkg::*;

   localparam int PANEL_W     = DEFAULT_PANEL_WIDTH;
   localparam int PANEL_H     = DEFAULT_PANEL_HEIGHT;
   localparam int MAXX        = PANEL_W - 1;
   localparam int MAXY        = PANEL_H - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 30;

   typedef struct {
      bit                     func;
      logic signed [IN_W-1:0] x_first;
      logic signed [IN_W-1:0] y_first;
      logic signed [IN_W-1:0] x_second;
      logic signed [IN_W-1:0] y_second;
      logic [COLOR_W-1:0]     pixel_color;
   } draw_req;

   class bus_txn_board;
      bit      landscape;
      bit      full_window;
      int      mismatches;
      rsp_type owed_txns[$];
      rsp_type batch[$];

      function void emit(kind_type k, logic [REG_W-1:0] idx, int v, int n);
         rsp_type t;
         t.kind        = k;
         t.reg_index   = idx;
         t.value       = v[VALUE_W-1:0];
         t.pixel_count = n[COUNT_W-1:0];
         t.last        = 1'b0;
         batch.push_back(t);
      endfunction

      function bit clamp_span(inout int a, inout int b, input int hi);
         if (a < 0) begin
            if (b < 0) return 1'b0;
            a = 0;
         end else if (a > hi) begin
            if (b > hi) return 1'b0;
            a = hi;
         end
         if (b < 0) begin
            b = 0;
         end else if (b > hi) begin
            b = hi;
         end
         return 1'b1;
      endfunction

      function void take_command(draw_req c);
         int      x1, y1, x2, y2, t, area;
         rsp_type tail;
         x1 = c.x_first;
         y1 = c.y_first;
         x2 = c.x_second;
         y2 = c.y_second;
         batch.delete();
         if (!c.func) begin
            if (landscape) begin
               t  = y2;
               y2 = MAXY - x1;
               x1 = y1;
               y1 = MAXY - x2;
               x2 = t;
            end
            if (clamp_span(x1, x2, MAXX) && clamp_span(y1, y2, MAXY)) begin
               area = 0;
               if (x2 >= x1 && y2 >= y1) area = (x2 - x1 + 1) * (y2 - y1 + 1);
               if (area > int'(COUNT_MAX)) area = int'(COUNT_MAX);
               emit(KIND_REG, REG_CUR_X, x1, 0);
               emit(KIND_REG, REG_CUR_Y, y1, 0);
               emit(KIND_REG, REG_WIN_X0, x1, 0);
               emit(KIND_REG, REG_WIN_Y0, y1, 0);
               emit(KIND_REG, REG_WIN_X1, x2, 0);
               emit(KIND_REG, REG_WIN_Y1, y2, 0);
               emit(KIND_SEL, REG_GRAM, 0, 0);
               emit(KIND_BURST, REG_NONE, c.pixel_color, area);
               full_window = 1'b0;
            end
         end else begin
            if (landscape) begin
               t  = y1;
               y1 = MAXY - x1;
               x1 = t;
            end
            if (x1 >= 0 && x1 <= MAXX && y1 >= 0 && y1 <= MAXY) begin
               if (!full_window) begin
                  emit(KIND_REG, REG_WIN_X0, 0, 0);
                  emit(KIND_REG, REG_WIN_X1, MAXX, 0);
                  emit(KIND_REG, REG_WIN_Y0, 0, 0);
                  emit(KIND_REG, REG_WIN_Y1, MAXY, 0);
                  emit(KIND_SEL, REG_GRAM, 0, 0);
                  full_window = 1'b1;
               end
               emit(KIND_REG, REG_CUR_X, x1, 0);
               emit(KIND_REG, REG_CUR_Y, y1, 0);
               emit(KIND_SEL, REG_GRAM, 0, 0);
               emit(KIND_BURST, REG_NONE, c.pixel_color, 1);
            end
         end
         if (batch.size() > 0) begin
            tail      = batch.pop_back();
            tail.last = 1'b1;
            batch.push_back(tail);
            foreach (batch[i]) owed_txns.push_back(batch[i]);
         end
      endfunction

      function void match_txn(logic [1:0] k, logic [REG_W-1:0] idx, logic [VALUE_W-1:0] v,
                              logic [COUNT_W-1:0] n, logic l);
         rsp_type e;
         if (owed_txns.size() == 0) begin
            $error("unexpected transaction: kind %0d reg_index 0x%0h value 0x%0h count %0d",
                   k, idx, v, n);
            mismatches++;
            return;
         end
         e = owed_txns.pop_front();
         if (k !== e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, k);
            mismatches++;
         end
         if (idx !== e.reg_index) begin
            $error("reg_index: expected 0x%0h, actual 0x%0h", e.reg_index, idx);
            mismatches++;
         end
         if (v !== e.value) begin
            $error("value: expected 0x%0h, actual 0x%0h", e.value, v);
            mismatches++;
         end
         if (n !== e.pixel_count) begin
            $error("pixel_count: expected %0d, actual %0d", e.pixel_count, n);
            mismatches++;
         end
         if (l !== e.last) begin
            $error("last: expected %0b, actual %0b", e.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   int   req_idle_pct;
   int   rsp_idle_pct;
   int   hold_orders;
   int   hold_seen;
   int   hold_left;
   int   cycle_count;

   bus_txn_board board;

   lwcf_req_if req_ch ();
   lwcf_rsp_if rsp_ch ();

   lcd_window_clip_fill_sequencer #(
      .PANEL_WIDTH  (PANEL_W),
      .PANEL_HEIGHT (PANEL_H)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.match_txn(rsp_ch.kind, rsp_ch.reg_index, rsp_ch.value, rsp_ch.pixel_count,
                         rsp_ch.last);
      end
      if (hold_seen != hold_orders) begin
         hold_seen    <= hold_orders;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic draw_req mk(bit f, int x1, int y1, int x2, int y2, int col);
      draw_req c;
      c.func        = f;
      c.x_first     = x1[IN_W-1:0];
      c.y_first     = y1[IN_W-1:0];
      c.x_second    = x2[IN_W-1:0];
      c.y_second    = y2[IN_W-1:0];
      c.pixel_color = col[COLOR_W-1:0];
      return c;
   endfunction

   function automatic logic signed [IN_W-1:0] rand_coord(int hi);
      int pick;
      int v;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         v = $urandom_range(0, hi);
      end else if (pick < 16) begin
         v = int'($urandom_range(0, hi + 40)) - 20;
      end else if (pick < 18) begin
         v = $urandom_range(0, 65535);
      end else begin
         case ($urandom_range(0, 5))
            0: v = -32768;
            1: v = 32767;
            2: v = -1;
            3: v = 0;
            4: v = hi;
            default: v = hi + 1;
         endcase
      end
      return v[IN_W-1:0];
   endfunction

   function automatic draw_req rand_cmd(bit land);
      draw_req c;
      int      xh, yh, a, b;
      xh            = land ? MAXY : MAXX;
      yh            = land ? MAXX : MAXY;
      c.func        = 1'($urandom_range(0, 1));
      c.pixel_color = COLOR_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) < 6) begin
         a            = $urandom_range(0, xh);
         b            = $urandom_range(a, xh);
         c.x_first    = a[IN_W-1:0];
         c.x_second   = b[IN_W-1:0];
         a            = $urandom_range(0, yh);
         b            = $urandom_range(a, yh);
         c.y_first    = a[IN_W-1:0];
         c.y_second   = b[IN_W-1:0];
      end else begin
         c.x_first    = rand_coord(xh);
         c.y_first    = rand_coord(yh);
         c.x_second   = rand_coord(xh);
         c.y_second   = rand_coord(yh);
      end
      return c;
   endfunction

   task automatic send_cmd(draw_req c);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= c.func;
      req_ch.x_first     <= c.x_first;
      req_ch.y_first     <= c.y_first;
      req_ch.x_second    <= c.x_second;
      req_ch.y_second    <= c.y_second;
      req_ch.pixel_color <= c.pixel_color;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.take_command(c);
   endtask

   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.owed_txns.size() != 0) @(posedge clock);
   endtask

   task automatic set_landscape(bit mode);
      pause_until_drained();
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.landscape = mode;
   endtask

   task automatic random_run(int count, int hold_at, int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_orders++;
         if (i == pause_at) pause_until_drained();
         send_cmd(rand_cmd(board.landscape));
      end
   endtask

   initial begin
      board              = new();
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.func        = 1'b0;
      req_ch.x_first     = '0;
      req_ch.y_first     = '0;
      req_ch.x_second    = '0;
      req_ch.y_second    = '0;
      req_ch.pixel_color = '0;
      rsp_ch.ready       = 1'b0;
      req_idle_pct       = 26;
      rsp_idle_pct       = 26;
      hold_orders        = 0;
      hold_seen          = 0;
      hold_left          = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_landscape(1'b0);
      send_cmd(mk(1, 0, 0, 0, 0, 16'hFFFF));
      send_cmd(mk(1, MAXX, MAXY, -32768, 32767, 16'h0000));
      send_cmd(mk(1, PANEL_W, 0, 0, 0, 16'h1234));
      send_cmd(mk(1, 0, PANEL_H, 0, 0, 16'h1234));
      send_cmd(mk(1, -1, 5, 0, 0, 16'h1234));
      send_cmd(mk(0, 0, 0, MAXX, MAXY, 16'hF800));
      send_cmd(mk(0, -32768, -32768, 32767, 32767, 16'h07E0));
      send_cmd(mk(0, -5, 10, -1, 20, 16'h001F));
      send_cmd(mk(0, PANEL_W, 0, 300, 10, 16'h001F));
      send_cmd(mk(0, 0, PANEL_H, 10, 400, 16'h001F));
      send_cmd(mk(0, 10, -9, 20, -2, 16'h001F));
      send_cmd(mk(0, 100, 50, 10, 60, 16'hAAAA));
      send_cmd(mk(0, 10, 60, 20, 50, 16'h5555));
      send_cmd(mk(0, 200, 0, 300, 10, 16'hFFFF));
      send_cmd(mk(0, 300, 0, -5, 10, 16'h0000));
      send_cmd(mk(0, -10, 100, 500, 100, 16'h8001));
      send_cmd(mk(0, 5, 5, 5, 5, 16'h7FFE));
      send_cmd(mk(1, 120, 160, 0, 0, 16'hFFFF));
      send_cmd(mk(1, 120, 161, 0, 0, 16'h0000));
      random_run(100, 40, 70);

      set_landscape(1'b1);
      send_cmd(mk(1, 0, 0, 0, 0, 16'hFFFF));
      send_cmd(mk(1, MAXY, MAXX, 0, 0, 16'h0000));
      send_cmd(mk(1, PANEL_H, 0, 0, 0, 16'h1111));
      send_cmd(mk(1, 0, PANEL_W, 0, 0, 16'h2222));
      send_cmd(mk(0, 0, 0, MAXY, MAXX, 16'h3333));
      send_cmd(mk(0, -10, -10, 400, 300, 16'h4444));
      send_cmd(mk(0, PANEL_H, 0, 400, 10, 16'h5555));
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_run(50, -1, -1);
      req_idle_pct = 26;
      rsp_idle_pct = 26;
      random_run(50, 20, -1);

      set_landscape(1'b0);
      random_run(100, -1, 50);

      set_landscape(1'b1);
      random_run(20, -1, -1);

      pause_until_drained();
      repeat (SETTLE) @(posedge clock);
      if (board.owed_txns.size() != 0) begin
         $error("%0d expected transactions never arrived", board.owed_txns.size());
         board.mismatches++;
      end
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
